// ----- rtl/gsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsv_pkg
// Shared types, constants and helpers for the GIF structure size validator.
// ----------------------------------------------------------------------------
package gsv_pkg;

  localparam int POS_BITS   = 32;
  localparam int SKIP_BITS  = 10;
  localparam int COUNT_BITS = 17;

  localparam logic [COUNT_BITS-1:0] MAX_BLOCK_RESET = 17'd65536;

  localparam logic [7:0] TRAILER_CODE   = 8'h3B;
  localparam logic [7:0] IMAGE_CODE     = 8'h2C;
  localparam logic [7:0] EXTENSION_CODE = 8'h21;

  localparam logic [SKIP_BITS-1:0] DESC_BYTES = 10'd9;

  // smallest well-formed file: signature, screen descriptor, trailer
  localparam logic [POS_BITS-1:0] MIN_FILE_SIZE = 32'd14;

  typedef enum logic [10:0] {
    PH_SIG     = 11'b000_0000_0001,
    PH_LSD     = 11'b000_0000_0010,
    PH_GCT     = 11'b000_0000_0100,
    PH_MARKER  = 11'b000_0000_1000,
    PH_DESC    = 11'b000_0001_0000,
    PH_LCT     = 11'b000_0010_0000,
    PH_MINCODE = 11'b000_0100_0000,
    PH_LABEL   = 11'b000_1000_0000,
    PH_SUBLEN  = 11'b001_0000_0000,
    PH_SUBDATA = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic                hit;
    logic                ok;
    logic [POS_BITS-1:0] size;
  } result_t;

  // "GIF8?a"; position four is checked separately
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h47;
      3'd1:    v = 8'h49;
      3'd2:    v = 8'h46;
      3'd3:    v = 8'h38;
      3'd4:    v = 8'h37;
      3'd5:    v = 8'h61;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [SKIP_BITS-1:0] table_bytes(input logic [2:0] n);
    logic [3:0] sh;
    sh = {1'b0, n} + 4'd1;
    return SKIP_BITS'(10'd3 << sh);
  endfunction

endpackage

// ----- rtl/gif_structure_size_validator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_structure_size_validator_core
// Verdict path: input register, parser, output register; a pending verdict can stall it.
// Throughput: one byte per cycle; input stalls only while a verdict waits.
// Reset: rst clears parse state and handshakes; limit returns to 65536.
// ----------------------------------------------------------------------------
module gif_structure_size_validator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gsv_pkg::COUNT_BITS-1:0] cfg_data,
  input  logic                           data_valid,
  output logic                           data_ready,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic                           valid_res,
  output logic [gsv_pkg::POS_BITS-1:0]   structured_size
);
  import gsv_pkg::*;

  logic [COUNT_BITS-1:0] max_block_count;
  logic                  vld, last_q, take, free;
  logic [7:0]            byte_q;
  result_t               res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_count <= MAX_BLOCK_RESET;
    end else if (cfg_we) begin
      max_block_count <= cfg_data;
    end
  end

  assign take = vld && (!res.hit || free);

  gsv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (take),
    .vld        (vld),
    .byte_q     (byte_q),
    .last_q     (last_q)
  );

  gsv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .byte_q    (byte_q),
    .last_q    (last_q),
    .max_count (max_block_count),
    .res       (res)
  );

  gsv_out_stage u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (take && res.hit),
    .res             (res),
    .free            (free),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .valid_res       (valid_res),
    .structured_size (structured_size)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> structured_size == '0)
    else $error("invalid verdict with nonzero size");

  a_valid_min_size: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res |-> structured_size >= MIN_FILE_SIZE)
    else $error("valid verdict shorter than minimal file");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !data_ready |-> res_valid && !res_ready)
    else $error("input stalled without a pending verdict");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

// ----- rtl/gsv_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsv_in_stage
// Input register for one byte transfer; drains when the parser steps.
// ----------------------------------------------------------------------------
module gsv_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,
  output logic       vld,
  output logic [7:0] byte_q,
  output logic       last_q
);
  import gsv_pkg::*;

  assign data_ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (data_ready) begin
      vld <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

endmodule

// ----- rtl/gsv_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsv_parser
// Per-byte GIF structure walk: phase, offset, skip and block count state.
// ----------------------------------------------------------------------------
module gsv_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [7:0]                     byte_q,
  input  logic                           last_q,
  input  logic [gsv_pkg::COUNT_BITS-1:0] max_count,
  output gsv_pkg::result_t               res
);
  import gsv_pkg::*;

  phase_t                phase, phase_next;
  logic [POS_BITS-1:0]   pos, pos_next;
  logic [SKIP_BITS-1:0]  skip, skip_next;
  logic [COUNT_BITS-1:0] blocks, blocks_next;
  logic [7:0]            lo_byte, lo_byte_next;
  logic [7:0]            flags, flags_next;
  logic                  fail, pass, over, verdict;
  logic                  limit_hit;

  assign limit_hit = blocks >= max_count;
  assign over      = pos == {POS_BITS{1'b1}};

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    skip_next    = skip;
    blocks_next  = blocks;
    lo_byte_next = lo_byte;
    flags_next   = flags;
    fail         = 1'b0;
    pass         = 1'b0;

    case (phase)
      PH_SIG: begin
        if (pos[2:0] == 3'd4) begin
          fail = !(byte_q inside {8'h37, 8'h39});
        end else begin
          fail = byte_q != sig_byte(pos[2:0]);
        end
        if (pos[2:0] == 3'd5) phase_next = PH_LSD;
      end
      PH_LSD: begin
        case (pos[3:0])
          4'd6, 4'd8:  lo_byte_next = byte_q;
          4'd7, 4'd9:  fail = {byte_q, lo_byte} == 16'd0;
          4'd10:       flags_next = byte_q;
          4'd12: begin
            if (flags[7]) begin
              skip_next  = table_bytes(flags[2:0]);
              phase_next = PH_GCT;
            end else begin
              phase_next = PH_MARKER;
            end
          end
          default: ;
        endcase
      end
      PH_GCT, PH_LCT, PH_SUBDATA: begin
        skip_next = skip - 10'd1;
        if (skip_next == '0) begin
          if (phase == PH_GCT)      phase_next = PH_MARKER;
          else if (phase == PH_LCT) phase_next = PH_MINCODE;
          else                      phase_next = PH_SUBLEN;
        end
      end
      PH_MARKER: begin
        if (limit_hit) begin
          fail = 1'b1;
        end else begin
          blocks_next = blocks + 17'd1;
          if (byte_q == TRAILER_CODE) begin
            pass = 1'b1;
          end else if (byte_q == IMAGE_CODE) begin
            skip_next  = DESC_BYTES;
            phase_next = PH_DESC;
          end else if (byte_q == EXTENSION_CODE) begin
            phase_next = PH_LABEL;
          end else begin
            fail = 1'b1;
          end
        end
      end
      PH_DESC: begin
        // skip counts down 9..1 over left, top, width, height, packed
        case (skip)
          10'd5, 10'd3: lo_byte_next = byte_q;
          10'd4, 10'd2: fail = {byte_q, lo_byte} == 16'd0;
          10'd1:        flags_next = byte_q;
          default: ;
        endcase
        skip_next = skip - 10'd1;
        if (skip_next == '0) begin
          if (flags_next[7]) begin
            skip_next  = table_bytes(flags_next[2:0]);
            phase_next = PH_LCT;
          end else begin
            phase_next = PH_MINCODE;
          end
        end
      end
      PH_MINCODE: begin
        fail       = !(byte_q inside {[8'd2:8'd8]});
        phase_next = PH_SUBLEN;
      end
      PH_LABEL: begin
        phase_next = PH_SUBLEN;
      end
      PH_SUBLEN: begin
        if (limit_hit) begin
          fail = 1'b1;
        end else begin
          blocks_next = blocks + 17'd1;
          if (byte_q == 8'd0) begin
            phase_next = PH_MARKER;
          end else begin
            skip_next  = {2'b00, byte_q};
            phase_next = PH_SUBDATA;
          end
        end
      end
      default: ;
    endcase

    verdict  = (phase != PH_DONE) && (over || fail || pass || last_q);
    res.hit  = verdict;
    res.ok   = pass && !over;
    res.size = (pass && !over) ? pos + 32'd1 : '0;

    if (verdict) begin
      phase_next = PH_DONE;
    end else if (phase != PH_DONE) begin
      pos_next = pos + 32'd1;
    end

    if (last_q) begin
      phase_next   = PH_SIG;
      pos_next     = '0;
      skip_next    = '0;
      blocks_next  = '0;
      lo_byte_next = '0;
      flags_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SIG;
      pos     <= '0;
      skip    <= '0;
      blocks  <= '0;
      lo_byte <= '0;
      flags   <= '0;
    end else if (step) begin
      phase   <= phase_next;
      pos     <= pos_next;
      skip    <= skip_next;
      blocks  <= blocks_next;
      lo_byte <= lo_byte_next;
      flags   <= flags_next;
    end
  end

endmodule

// ----- rtl/gsv_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsv_out_stage
// Result register holding one verdict until its transfer completes.
// ----------------------------------------------------------------------------
module gsv_out_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  gsv_pkg::result_t             res,
  output logic                         free,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         valid_res,
  output logic [gsv_pkg::POS_BITS-1:0] structured_size
);
  import gsv_pkg::*;

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      valid_res       <= res.ok;
      structured_size <= res.size;
    end
  end

endmodule

// ----- tb/tb_gif_structure_size_validator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_structure_size_validator_core
// Streams GIF files into the validator, one byte per transfer, and checks
// every verdict against a parser model kept inside the bench. Directed files
// cover signatures, screen and image sizes, color tables, code sizes,
// extensions, early ends, trailing bytes and the block limit. Random files
// follow, mostly well formed with some corrupted. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_gif_structure_size_validator_core;
  import gsv_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [47:0] SIG_TEXT = "GIF87a";
  localparam longint unsigned POS_LIMIT =
    (POS_BITS >= 32) ? 64'hFFFF_FFFF : ((64'd1 << POS_BITS) - 64'd1);

  typedef enum int { PARSE_GO, PARSE_BAD, PARSE_GOOD } parse_t;

  typedef struct {
    logic                ok;
    logic [POS_BITS-1:0] size;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [COUNT_BITS-1:0] cfg_data = '0;
  logic                  data_valid = 1'b0;
  logic                  data_ready;
  logic [7:0]            data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic                  valid_res;
  logic [POS_BITS-1:0]   structured_size;

  // parser model state
  phase_t                m_phase;
  longint unsigned       m_pos;
  logic [SKIP_BITS-1:0]  m_skip;
  logic [COUNT_BITS-1:0] m_blocks;
  logic [COUNT_BITS-1:0] m_limit;
  logic [7:0]            m_lo;
  logic [7:0]            m_flags;
  bit                    m_done;

  verdict_t   verdict_q[$];
  logic [7:0] file_buf[$];
  int         mismatches = 0;
  int         counted_bytes = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  bit         steady = 1'b0;

  gif_structure_size_validator_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .valid_res      (valid_res),
    .structured_size(structured_size)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model --
  function automatic void model_clear();
    m_phase  = PH_SIG;
    m_pos    = 0;
    m_skip   = '0;
    m_blocks = '0;
    m_lo     = '0;
    m_flags  = '0;
    m_done   = 1'b0;
  endfunction

  function automatic logic [SKIP_BITS-1:0] color_table_len(input logic [7:0] flags);
    return SKIP_BITS'(10'd6 << flags[2:0]);
  endfunction

  function automatic bit model_count();
    if (m_blocks >= m_limit) return 1'b0;
    m_blocks = m_blocks + 1'b1;
    return 1'b1;
  endfunction

  function automatic parse_t model_parse(input logic [7:0] b, input longint unsigned off);
    logic [SKIP_BITS-1:0] rel;
    case (m_phase)
      PH_SIG: begin
        if (off == 4) begin
          if (b != 8'h37 && b != 8'h39) return PARSE_BAD;
        end else if (b != SIG_TEXT[47 - 8*int'(off) -: 8]) begin
          return PARSE_BAD;
        end
        if (off == 5) m_phase = PH_LSD;
        return PARSE_GO;
      end
      PH_LSD: begin
        if (off == 6 || off == 8) m_lo = b;
        else if (off == 7 || off == 9) begin
          if ({b, m_lo} == 16'd0) return PARSE_BAD;
        end else if (off == 10) m_flags = b;
        if (off == 12) begin
          if (m_flags[7]) begin
            m_skip  = color_table_len(m_flags);
            m_phase = PH_GCT;
          end else begin
            m_phase = PH_MARKER;
          end
        end
        return PARSE_GO;
      end
      PH_GCT, PH_LCT, PH_SUBDATA: begin
        m_skip = m_skip - 1'b1;
        if (m_skip == '0) begin
          if (m_phase == PH_GCT) m_phase = PH_MARKER;
          else if (m_phase == PH_LCT) m_phase = PH_MINCODE;
          else m_phase = PH_SUBLEN;
        end
        return PARSE_GO;
      end
      PH_MARKER: begin
        if (!model_count()) return PARSE_BAD;
        if (b == TRAILER_CODE) return PARSE_GOOD;
        if (b == IMAGE_CODE) begin
          m_skip  = DESC_BYTES;
          m_phase = PH_DESC;
          return PARSE_GO;
        end
        if (b == EXTENSION_CODE) begin
          m_phase = PH_LABEL;
          return PARSE_GO;
        end
        return PARSE_BAD;
      end
      PH_DESC: begin
        rel = 10'd10 - m_skip;
        if (rel == 10'd5 || rel == 10'd7) m_lo = b;
        else if (rel == 10'd6 || rel == 10'd8) begin
          if ({b, m_lo} == 16'd0) return PARSE_BAD;
        end else if (rel == 10'd9) m_flags = b;
        m_skip = m_skip - 1'b1;
        if (m_skip == '0) begin
          if (m_flags[7]) begin
            m_skip  = color_table_len(m_flags);
            m_phase = PH_LCT;
          end else begin
            m_phase = PH_MINCODE;
          end
        end
        return PARSE_GO;
      end
      PH_MINCODE: begin
        if (b < 8'd2 || b > 8'd8) return PARSE_BAD;
        m_phase = PH_SUBLEN;
        return PARSE_GO;
      end
      PH_LABEL: begin
        m_phase = PH_SUBLEN;
        return PARSE_GO;
      end
      PH_SUBLEN: begin
        if (!model_count()) return PARSE_BAD;
        if (b == 8'd0) m_phase = PH_MARKER;
        else begin
          m_skip  = SKIP_BITS'(b);
          m_phase = PH_SUBDATA;
        end
        return PARSE_GO;
      end
      default: return PARSE_BAD;
    endcase
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    parse_t   v;
    verdict_t r;
    if (!m_done) begin
      counted_bytes++;
      if (m_pos >= POS_LIMIT) v = PARSE_BAD;
      else v = model_parse(b, m_pos);
      if (v == PARSE_GO && fin) v = PARSE_BAD;
      if (v != PARSE_GO) begin
        r.ok   = (v == PARSE_GOOD);
        r.size = r.ok ? POS_BITS'(m_pos + 1) : '0;
        verdict_q.push_back(r);
        m_done  = 1'b1;
        m_phase = PH_DONE;
      end else begin
        m_pos++;
      end
    end
    if (fin) model_clear();
  endfunction

  // ------------------------------------------------------------- builders --
  function automatic void put16(input logic [15:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
  endfunction

  function automatic void put_rand(input int n);
    repeat (n) file_buf.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] rand_dim();
    if ($urandom_range(3) == 0) return 16'($urandom_range(1, 3));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic void add_header(input bit v89, input logic [15:0] w,
                                     input logic [15:0] h, input logic [7:0] flags);
    for (int i = 0; i < 6; i++) begin
      if (i == 4) file_buf.push_back(v89 ? 8'h39 : 8'h37);
      else file_buf.push_back(SIG_TEXT[47 - 8*i -: 8]);
    end
    put16(w);
    put16(h);
    file_buf.push_back(flags);
    put_rand(2);
    if (flags[7]) put_rand(int'(color_table_len(flags)));
  endfunction

  function automatic void add_subs(input int n, input int maxlen);
    int len;
    repeat (n) begin
      len = $urandom_range(1, maxlen);
      file_buf.push_back(8'(len));
      put_rand(len);
    end
    file_buf.push_back(8'h00);
  endfunction

  function automatic void add_image(input logic [15:0] w, input logic [15:0] h,
                                    input logic [7:0] flags, input logic [7:0] mincode,
                                    input int nsub);
    file_buf.push_back(IMAGE_CODE);
    put_rand(4);
    put16(w);
    put16(h);
    file_buf.push_back(flags);
    if (flags[7]) put_rand(int'(color_table_len(flags)));
    file_buf.push_back(mincode);
    add_subs(nsub, 6);
  endfunction

  function automatic void add_ext(input logic [7:0] label, input int nsub, input int maxlen);
    file_buf.push_back(EXTENSION_CODE);
    file_buf.push_back(label);
    add_subs(nsub, maxlen);
  endfunction

  function automatic void build_random_file();
    logic [7:0] fl;
    int         cut;
    fl = 8'($urandom);
    fl[2:0] = ($urandom_range(15) == 0) ? 3'($urandom_range(3, 4)) : 3'($urandom_range(0, 2));
    add_header(1'($urandom), rand_dim(), rand_dim(), fl);
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(1) == 0) begin
        fl = 8'($urandom);
        fl[2:0] = 3'($urandom_range(0, 2));
        add_image(rand_dim(), rand_dim(), fl, 8'($urandom_range(2, 8)), $urandom_range(0, 2));
      end else begin
        add_ext(8'($urandom), $urandom_range(0, 2), 6);
      end
    end
    file_buf.push_back(TRAILER_CODE);
    if ($urandom_range(3) == 0) put_rand($urandom_range(1, 3));
    case ($urandom_range(9))
      7: file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom);
      8: begin
        cut = $urandom_range(1, file_buf.size() - 1);
        file_buf = file_buf[0:cut-1];
      end
      9: file_buf[$urandom_range(6, file_buf.size() - 1)] = $urandom_range(1) ? 8'h00 : IMAGE_CODE;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------- driving --
  task automatic feed_byte(input logic [7:0] b, input logic fin);
    while (!steady && $urandom_range(99) < 7) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    predict_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_buf[i]) feed_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
  endtask

  task automatic wait_idle();
    data_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_block_limit(input logic [COUNT_BITS-1:0] v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    m_limit = v;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("tb: mismatch on %s, want %0d got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- checks --
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin : check_verdict
    verdict_t e;
    if (!rst && res_valid && res_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected verdict", 32'd0, {31'd0, valid_res});
      end else begin
        e = verdict_q.pop_front();
        if (valid_res !== e.ok) report_mismatch("valid_res", {31'd0, e.ok}, {31'd0, valid_res});
        if (structured_size !== e.size) report_mismatch("structured_size", e.size, structured_size);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ----------------------------------------------------------------- tests --
  task automatic test_signatures();
    add_header(1'b0, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'hFFFF, 16'hFFFF, 8'h7F); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE);
    file_buf[0] = 8'h48; send_file();
    add_header(1'b1, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE);
    file_buf[3] = 8'h39; send_file();
    add_header(1'b1, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE);
    file_buf[4] = 8'h38; send_file();
    add_header(1'b0, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE);
    file_buf[5] = 8'h62; send_file();
  endtask

  task automatic test_screen();
    add_header(1'b1, 16'd0, 16'd5, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd5, 16'd0, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b0, 16'h0100, 16'h0001, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd2, 16'd2, 8'h80); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd2, 16'd2, 8'hFC);
    add_image(16'd4, 16'd4, 8'h00, 8'd2, 1);
    file_buf.push_back(TRAILER_CODE); send_file();
  endtask

  task automatic test_blocks();
    add_header(1'b1, 16'd8, 16'd8, 8'h00);
    add_image(16'd8, 16'd8, 8'h81, 8'd2, 2);
    add_image(16'hFFFF, 16'd1, 8'h40, 8'd8, 1);
    add_ext(8'hF9, 1, 6);
    add_ext(8'hFF, 0, 1);
    file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd8, 16'd8, 8'h00); add_image(16'd8, 16'd8, 8'h00, 8'd1, 1); send_file();
    add_header(1'b1, 16'd8, 16'd8, 8'h00); add_image(16'd8, 16'd8, 8'h00, 8'd9, 1); send_file();
    add_header(1'b1, 16'd8, 16'd8, 8'h00); add_image(16'd0, 16'd8, 8'h00, 8'd2, 1); send_file();
    add_header(1'b1, 16'd8, 16'd8, 8'h00); add_image(16'd8, 16'd0, 8'h00, 8'd2, 1); send_file();
    add_header(1'b1, 16'd8, 16'd8, 8'h00);
    file_buf.push_back(EXTENSION_CODE);
    file_buf.push_back(8'h01);
    file_buf.push_back(8'd255);
    put_rand(255);
    file_buf.push_back(8'h00);
    file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b0, 16'd8, 16'd8, 8'h00); file_buf.push_back(8'h00); send_file();
    add_header(1'b0, 16'd8, 16'd8, 8'h00); file_buf.push_back(8'hFF); send_file();
  endtask

  task automatic test_early_end();
    file_buf.push_back(8'h47); send_file();
    add_header(1'b1, 16'd3, 16'd3, 8'h00); send_file();
    add_header(1'b1, 16'd3, 16'd3, 8'h00); add_image(16'd3, 16'd3, 8'h00, 8'd4, 1); send_file();
    add_header(1'b1, 16'd3, 16'd3, 8'h00); add_ext(8'h21, 1, 6);
    file_buf = file_buf[0:15]; send_file();
  endtask

  task automatic test_trailing_bytes();
    add_header(1'b1, 16'd3, 16'd3, 8'h00); file_buf.push_back(TRAILER_CODE);
    put_rand(5); send_file();
    file_buf.push_back(8'h00); put_rand(12); send_file();
  endtask

  task automatic test_block_limit();
    set_block_limit(17'd1);
    add_header(1'b1, 16'd3, 16'd3, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
    add_header(1'b1, 16'd3, 16'd3, 8'h00); add_image(16'd3, 16'd3, 8'h00, 8'd2, 0);
    file_buf.push_back(TRAILER_CODE); send_file();
    set_block_limit(17'd2);
    add_header(1'b1, 16'd3, 16'd3, 8'h00); add_ext(8'h01, 0, 1);
    file_buf.push_back(TRAILER_CODE); send_file();
    set_block_limit(17'd3);
    add_header(1'b1, 16'd3, 16'd3, 8'h00); add_ext(8'h01, 0, 1);
    file_buf.push_back(TRAILER_CODE); send_file();
    set_block_limit(MAX_BLOCK_RESET);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_left = 300;
    repeat (8) begin
      file_buf.push_back(8'($urandom_range(0, 70))); send_file();
    end
    add_header(1'b0, 16'd1, 16'd1, 8'h00); file_buf.push_back(TRAILER_CODE); send_file();
  endtask

  task automatic test_random_files(input logic [COUNT_BITS-1:0] limit, input int budget);
    int start;
    set_block_limit(limit);
    start = counted_bytes;
    while (counted_bytes - start < budget) begin
      build_random_file();
      send_file();
    end
  endtask

  task automatic test_no_idle();
    wait_idle();
    steady = 1'b1;
    test_random_files(MAX_BLOCK_RESET, 100);
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    m_limit = MAX_BLOCK_RESET;
    model_clear();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_signatures();
    test_screen();
    test_blocks();
    test_early_end();
    test_trailing_bytes();
    test_block_limit();
    test_backpressure();
    test_random_files(MAX_BLOCK_RESET, 60);
    test_random_files(17'($urandom_range(2, 6)), 30);
    test_random_files(17'd1, 15);
    test_no_idle();
    test_random_files(17'($urandom_range(8, 40)), 25);
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gsv_pkg.sv
rtl/gsv_in_stage.sv
rtl/gsv_parser.sv
rtl/gsv_out_stage.sv
rtl/gif_structure_size_validator_core.sv
tb/tb_gif_structure_size_validator_core.sv
